>>> src/ssnf_pkg.sv
// shared constants, command struct and lookup functions for the seven-segment formatter
`default_nettype none

package ssnf_pkg;

   localparam int MAX_DIGITS  = 8;
   localparam int FRAC_BITS   = 16;
   localparam int VALUE_W     = 48;
   localparam int INT_W       = VALUE_W - FRAC_BITS;
   localparam int POW_W       = 24;
   localparam int PROD_W      = FRAC_BITS + POW_W;
   localparam int IBCD_LEN    = 10;
   localparam int FBCD_LEN    = 8;
   localparam int CONV_STEPS  = INT_W;
   localparam int CNT_W       = $clog2(CONV_STEPS);
   localparam int USED_W      = 4;
   localparam int TOTAL_W     = 5;
   localparam int PLACES_W    = 3;
   localparam int GLYPH_W     = 5;

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

   localparam logic [7:0] SEG_BLANK = 8'h00;
   localparam logic [7:0] SEG_MINUS = 8'h40;
   localparam logic [7:0] SEG_DOT   = 8'h80;

   localparam logic [GLYPH_W-1:0] GLYPH_NONE = 5'd16;

   typedef logic [IBCD_LEN-1:0][3:0]    ibcd_type;
   typedef logic [FBCD_LEN-1:0][3:0]    fbcd_type;
   typedef logic [MAX_DIGITS-1:0][7:0]  seg_row_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic adj;
      logic shift;
      logic fmt;
   } ssnf_cmd_type;

   function automatic logic [POW_W-1:0] pow10_of(input logic [PLACES_W-1:0] p);
      logic [POW_W-1:0] r;
      case (p)
         3'd0: r = 24'd1;
         3'd1: r = 24'd10;
         3'd2: r = 24'd100;
         3'd3: r = 24'd1000;
         3'd4: r = 24'd10000;
         3'd5: r = 24'd100000;
         3'd6: r = 24'd1000000;
         3'd7: r = 24'd10000000;
         default: r = 24'd1;
      endcase
      return r;
   endfunction

   // hex digits, then none/minus/top c/degree; other codes blank
   function automatic logic [7:0] glyph_seg(input logic [GLYPH_W-1:0] g);
      logic [7:0] s;
      case (g)
         5'd0:  s = 8'h3F;
         5'd1:  s = 8'h06;
         5'd2:  s = 8'h5B;
         5'd3:  s = 8'h4F;
         5'd4:  s = 8'h66;
         5'd5:  s = 8'h6D;
         5'd6:  s = 8'h7D;
         5'd7:  s = 8'h07;
         5'd8:  s = 8'h7F;
         5'd9:  s = 8'h6F;
         5'd10: s = 8'h77;
         5'd11: s = 8'h7C;
         5'd12: s = 8'h39;
         5'd13: s = 8'h5E;
         5'd14: s = 8'h79;
         5'd15: s = 8'h71;
         5'd17: s = 8'h40;
         5'd18: s = 8'h61;
         5'd19: s = 8'h63;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> src/ssnf_ctrl.sv
// sequencing state machine and result handshake for the seven-segment formatter
`default_nettype none

module ssnf_ctrl
   import ssnf_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output ssnf_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_ADJ  = 5'b00100,
      S_CONV = 5'b01000,
      S_FMT  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADJ;
         end
         S_ADJ: begin
            cmd.adj  = 1'b1;
            step_in  = '0;
            state_in = S_CONV;
         end
         S_CONV: begin
            cmd.shift = 1'b1;
            step_in   = step_ff + CNT_W'(1);
            if (step_ff == CNT_W'(CONV_STEPS - 1)) begin
               state_in = S_FMT;
            end
         end
         S_FMT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.fmt  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.fmt) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> src/ssnf_dp.sv
// datapath: magnitude split, fraction rounding, shift-add bcd conversion and layout
`default_nettype none

module ssnf_dp
   import ssnf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ssnf_cmd_type         cmd,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [PLACES_W-1:0]  req_frac_places,
   input  wire logic [GLYPH_W-1:0]   req_glyph,
   input  wire logic                 csr_wr_en,
   input  wire logic [USED_W-1:0]    csr_wr_data,
   output seg_row_type               seg,
   output logic                      overflow
);

   // add 3 to every digit of 5 or more, then shift left with b coming in
   function automatic ibcd_type dd_step(input ibcd_type bcd, input logic b);
      ibcd_type              adj;
      logic [4*IBCD_LEN-1:0] flat;
      for (int k = 0; k < IBCD_LEN; k++) begin
         adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
      end
      flat = adj;
      return {flat[4*IBCD_LEN-2:0], b};
   endfunction

   logic [USED_W-1:0]   digit_count_ff;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [PLACES_W-1:0] places_ff, places_in;
   logic [GLYPH_W-1:0]  glyph_ff, glyph_in;
   logic                has_glyph_ff, has_glyph_in;
   logic                neg_ff, neg_in;
   logic [INT_W-1:0]    ipart_ff, ipart_in;
   logic [FRAC_BITS-1:0] fpart_ff, fpart_in;
   logic [POW_W-1:0]    pow10_ff, pow10_in;
   logic [POW_W-1:0]    fdig_ff, fdig_in;
   logic [INT_W-1:0]    int_sr_ff, int_sr_in;
   logic [INT_W-1:0]    frac_sr_ff, frac_sr_in;
   ibcd_type            int_bcd_ff, int_bcd_in;
   fbcd_type            frac_bcd_ff, frac_bcd_in;
   seg_row_type         seg_ff, seg_in;
   logic                ovf_ff, ovf_in;

   logic [VALUE_W-1:0]  raw;
   logic [VALUE_W-1:0]  mag;
   logic [USED_W-1:0]   used_now;
   logic                has_glyph_now;
   logic [USED_W-1:0]   lim;
   logic [PROD_W-1:0]   prod;
   logic                carry;
   ibcd_type            frac_wide;
   ibcd_type            frac_step;
   logic [USED_W-1:0]   ndig;
   logic [TOTAL_W-1:0]  total;
   logic                ovf_now;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= USED_W'(MAX_DIGITS);
      end else if (csr_wr_en) begin
         digit_count_ff <= csr_wr_data;
      end
   end

   // item load: clamp counts, take magnitude apart
   always_comb begin
      raw = req_value;
      mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
      if (digit_count_ff == '0) begin
         used_now = USED_W'(1);
      end else if (digit_count_ff > USED_W'(MAX_DIGITS)) begin
         used_now = USED_W'(MAX_DIGITS);
      end else begin
         used_now = digit_count_ff;
      end
      has_glyph_now = (req_glyph != GLYPH_NONE);
      if (used_now - USED_W'(1) >= USED_W'(has_glyph_now)) begin
         lim = used_now - USED_W'(1) - USED_W'(has_glyph_now);
      end else begin
         lim = '0;
      end
   end

   // fraction scaling and rounding
   always_comb begin
      prod  = PROD_W'(fpart_ff) * PROD_W'(pow10_ff) + ROUND_HALF;
      carry = (fdig_ff >= pow10_ff);
      frac_wide = {{(4 * (IBCD_LEN - FBCD_LEN)){1'b0}}, frac_bcd_ff};
      frac_step = dd_step(frac_wide, frac_sr_ff[INT_W-1]);
   end

   // layout of the finished digits
   always_comb begin
      logic [USED_W-1:0] r;
      logic [USED_W-1:0] rf;
      logic [USED_W-1:0] ri;
      logic [7:0]        s;
      ndig = USED_W'(1);
      for (int k = 0; k < IBCD_LEN; k++) begin
         if (int_bcd_ff[k] != 4'd0) begin
            ndig = USED_W'(k + 1);
         end
      end
      total = TOTAL_W'(ndig) + TOTAL_W'(places_ff) + TOTAL_W'(neg_ff)
            + TOTAL_W'(has_glyph_ff);
      ovf_now = (total > TOTAL_W'(used_ff));
      for (int p = 0; p < MAX_DIGITS; p++) begin
         s  = SEG_BLANK;
         r  = '0;
         rf = '0;
         ri = '0;
         if (USED_W'(p) < used_ff) begin
            if (ovf_now) begin
               s = SEG_MINUS;
            end else begin
               // count positions from the right edge
               r = used_ff - USED_W'(p) - USED_W'(1);
               if (has_glyph_ff && (r == '0)) begin
                  s = glyph_seg(glyph_ff);
               end else begin
                  rf = r - USED_W'(has_glyph_ff);
                  if (rf < USED_W'(places_ff)) begin
                     s = glyph_seg(GLYPH_W'(frac_bcd_ff[rf[PLACES_W-1:0]]));
                  end else begin
                     ri = rf - USED_W'(places_ff);
                     if (ri < ndig) begin
                        s = glyph_seg(GLYPH_W'(int_bcd_ff[ri]));
                        if ((ri == '0) && (places_ff != '0)) begin
                           s = s | SEG_DOT;
                        end
                     end else if ((ri == ndig) && neg_ff) begin
                        s = SEG_MINUS;
                     end
                  end
               end
            end
         end
         seg_in[p] = s;
      end
      ovf_in = ovf_now;
      if (!cmd.fmt) begin
         seg_in = seg_ff;
         ovf_in = ovf_ff;
      end
   end

   always_comb begin
      used_in      = used_ff;
      places_in    = places_ff;
      glyph_in     = glyph_ff;
      has_glyph_in = has_glyph_ff;
      neg_in       = neg_ff;
      ipart_in     = ipart_ff;
      fpart_in     = fpart_ff;
      pow10_in     = pow10_ff;
      fdig_in      = fdig_ff;
      int_sr_in    = int_sr_ff;
      frac_sr_in   = frac_sr_ff;
      int_bcd_in   = int_bcd_ff;
      frac_bcd_in  = frac_bcd_ff;
      if (cmd.load) begin
         used_in      = used_now;
         places_in    = ({1'b0, req_frac_places} > lim) ? lim[PLACES_W-1:0]
                                                        : req_frac_places;
         glyph_in     = req_glyph;
         has_glyph_in = has_glyph_now;
         neg_in       = raw[VALUE_W-1];
         ipart_in     = mag[VALUE_W-1:FRAC_BITS];
         fpart_in     = mag[FRAC_BITS-1:0];
         pow10_in     = pow10_of(places_in);
      end
      if (cmd.mul) begin
         fdig_in = prod[PROD_W-1:FRAC_BITS];
      end
      if (cmd.adj) begin
         // rounding carry moves into the integer part
         int_sr_in   = ipart_ff + INT_W'(carry);
         frac_sr_in  = INT_W'(carry ? fdig_ff - pow10_ff : fdig_ff);
         int_bcd_in  = '0;
         frac_bcd_in = '0;
      end
      if (cmd.shift) begin
         int_sr_in   = {int_sr_ff[INT_W-2:0], 1'b0};
         frac_sr_in  = {frac_sr_ff[INT_W-2:0], 1'b0};
         int_bcd_in  = dd_step(int_bcd_ff, int_sr_ff[INT_W-1]);
         frac_bcd_in = frac_step[FBCD_LEN-1:0];
      end
   end

   always_ff @(posedge clock) begin
      used_ff      <= used_in;
      places_ff    <= places_in;
      glyph_ff     <= glyph_in;
      has_glyph_ff <= has_glyph_in;
      neg_ff       <= neg_in;
      ipart_ff     <= ipart_in;
      fpart_ff     <= fpart_in;
      pow10_ff     <= pow10_in;
      fdig_ff      <= fdig_in;
      int_sr_ff    <= int_sr_in;
      frac_sr_ff   <= frac_sr_in;
      int_bcd_ff   <= int_bcd_in;
      frac_bcd_ff  <= frac_bcd_in;
      seg_ff       <= seg_in;
      ovf_ff       <= ovf_in;
   end

   assign seg      = seg_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire

>>> src/seven_segment_number_formatter_top.sv
// top level of the seven-segment number formatter
// an accepted word goes through the mul, adj, conv and fmt states, then sets rsp_valid
// a new word is taken only back in idle, after the 32-step shift-add bcd conversion
// the output register holds a finished word while the next one is being converted
// reset: synchronous, active high; clears the state machine and rsp_valid, sets digit_count to 8
`default_nettype none

module seven_segment_number_formatter_top
   import ssnf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic [PLACES_W-1:0]       req_frac_places,
   input  wire logic [GLYPH_W-1:0]        req_glyph,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [7:0]                     rsp_seg0,
   output logic [7:0]                     rsp_seg1,
   output logic [7:0]                     rsp_seg2,
   output logic [7:0]                     rsp_seg3,
   output logic [7:0]                     rsp_seg4,
   output logic [7:0]                     rsp_seg5,
   output logic [7:0]                     rsp_seg6,
   output logic [7:0]                     rsp_seg7,
   output logic                           rsp_overflow,
   input  wire logic                      csr_wr_en,
   input  wire logic [USED_W-1:0]         csr_wr_data
);

   ssnf_cmd_type cmd;
   seg_row_type  seg;

   ssnf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ssnf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_value       (req_value),
      .req_frac_places (req_frac_places),
      .req_glyph       (req_glyph),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .seg             (seg),
      .overflow        (rsp_overflow)
   );

   assign rsp_seg0 = seg[0];
   assign rsp_seg1 = seg[1];
   assign rsp_seg2 = seg[2];
   assign rsp_seg3 = seg[3];
   assign rsp_seg4 = seg[4];
   assign rsp_seg5 = seg[5];
   assign rsp_seg6 = seg[6];
   assign rsp_seg7 = seg[7];

endmodule

`default_nettype wire

>>> src/ssnf_checker.sv
// port-level checks for the seven-segment formatter, bound to the top level
`default_nettype none

module ssnf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_seg0,
   input wire logic [7:0]  rsp_seg7,
   input wire logic        rsp_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seg0) && $stable(rsp_seg7)
         && $stable(rsp_overflow))
      else $error("result word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after acceptance");

   a_ovf_dashes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_seg0 == 8'h40)
      else $error("overflow word without leading dash");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind seven_segment_number_formatter_top ssnf_checker u_ssnf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_seg0     (rsp_seg0),
   .rsp_seg7     (rsp_seg7),
   .rsp_overflow (rsp_overflow)
);

`default_nettype wire
